@@ sv/brc_pkg.sv @@
package brc_pkg;

  localparam int unsigned CoefW   = 32;
  localparam int unsigned NumCoef = 5;
  localparam int unsigned IdxW    = 3;

  localparam logic [IdxW-1:0] RegAc1Ac2 = 3'd0;
  localparam logic [IdxW-1:0] RegAc3Ac4 = 3'd1;
  localparam logic [IdxW-1:0] RegAc5Ac6 = 3'd2;
  localparam logic [IdxW-1:0] RegB1B2   = 3'd3;
  localparam logic [IdxW-1:0] RegMcMd   = 3'd4;

  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] HalfScale  = 32'd32768;
  localparam logic [31:0] PressScale = 32'd50000;
  localparam logic [31:0] SqCoef     = 32'd3038;
  localparam logic [31:0] LinCoef    = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] PressBias  = 32'd3791;

  typedef struct packed {
    logic signed [31:0] ac1;
    logic signed [31:0] ac2;
    logic signed [31:0] ac3;
    logic [31:0]        ac4;
    logic [31:0]        ac5;
    logic [31:0]        ac6;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] mc;
    logic signed [31:0] md;
  } coef_t;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [23:0] raw_press;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temp_tenths;
    logic signed [31:0] pressure_pa;
    logic               div_error;
  } out_item_t;

endpackage

@@ sv/brc_in_if.sv @@
interface brc_in_if;
  logic                valid;
  logic                ready;
  logic [15:0]         raw_temp;
  logic [23:0]         raw_press;
  modport source (output valid, raw_temp, raw_press, input ready);
  modport sink (input valid, raw_temp, raw_press, output ready);
endinterface

@@ sv/brc_out_if.sv @@
interface brc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temp_tenths;
  logic signed [31:0] pressure_pa;
  logic               div_error;
  modport source (output valid, temp_tenths, pressure_pa, div_error, input ready);
  modport sink (input valid, temp_tenths, pressure_pa, div_error, output ready);
endinterface

@@ sv/barometer_raw_compensation_top.sv @@
// Path from input item to result: two 32-stage dividers plus nine arithmetic
// stages, one output register; one item per cycle while the sink does not stall.
// The whole pipeline advances together; a two-entry skid buffer at the output
// keeps input ready high while the sink stalls, until its skid slot fills.
// Synchronous active-high reset clears valid bits and the coefficients to 0.
module barometer_raw_compensation_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [brc_pkg::IdxW-1:0]  cfg_index,
  input  logic [brc_pkg::CoefW-1:0] cfg_data,
  brc_in_if.sink                    in_ch,
  brc_out_if.source                 out_ch
);
  brc_pkg::coef_t     coef;
  brc_pkg::in_item_t  in_item;
  brc_pkg::out_item_t core_item, main_item, skid_item;
  logic               core_v, main_v, skid_v, en;

  brc_cfg u_cfg (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .coef);

  // pipeline moves while the skid slot is free
  assign en = !skid_v;
  assign in_ch.ready = en;
  assign in_item = '{raw_temp: in_ch.raw_temp, raw_press: in_ch.raw_press};

  brc_core u_core (
    .clk, .rst, .en, .coef,
    .in_valid (in_ch.valid),
    .in_item,
    .out_valid(core_v),
    .out_item (core_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (!main_v || out_ch.ready) begin
        main_v <= skid_v || (en && core_v);
        skid_v <= 1'b0;
      end else if (en && core_v) begin
        skid_v <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!main_v || out_ch.ready) begin
      main_item <= skid_v ? skid_item : core_item;
    end else if (en && core_v) begin
      skid_item <= core_item;
    end
  end

  assign out_ch.valid       = main_v;
  assign out_ch.temp_tenths = main_item.temp_tenths;
  assign out_ch.pressure_pa = main_item.pressure_pa;
  assign out_ch.div_error   = main_item.div_error;
endmodule

@@ sv/brc_div.sv @@
// Pipelined unsigned divider, one quotient bit per stage, 32 stages.
// Sideband travels with each item. Advances when en is high.
module brc_div #(
  parameter int unsigned SideW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [31:0]      num,
  input  logic [31:0]      den,
  input  logic [SideW-1:0] side_in,
  output logic             out_valid,
  output logic [31:0]      quot,
  output logic [SideW-1:0] side_out
);
  localparam int unsigned Steps = 32;

  logic [Steps:0]      vld;
  logic [31:0]         rem [Steps+1];
  logic [31:0]         qn  [Steps+1];
  logic [31:0]         dv  [Steps+1];
  logic [SideW-1:0]    sd  [Steps+1];

  always_comb begin
    vld[0] = in_valid;
    rem[0] = '0;
    qn[0]  = num;
    dv[0]  = den;
    sd[0]  = side_in;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] diff;
    assign trial = {rem[s], qn[s][31]};
    assign diff  = trial - {1'b0, dv[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[32]) begin
          rem[s+1] <= diff[31:0];
          qn[s+1]  <= {qn[s][30:0], 1'b1};
        end else begin
          rem[s+1] <= trial[31:0];
          qn[s+1]  <= {qn[s][30:0], 1'b0};
        end
        dv[s+1] <= dv[s];
        sd[s+1] <= sd[s];
      end
    end
  end

  assign out_valid = vld[Steps];
  assign quot      = qn[Steps];
  assign side_out  = sd[Steps];
endmodule

@@ sv/brc_cfg.sv @@
module brc_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [brc_pkg::IdxW-1:0]  cfg_index,
  input  logic [brc_pkg::CoefW-1:0] cfg_data,
  output brc_pkg::coef_t            coef
);
  logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1_ac2 <= '0;
      ac3_ac4 <= '0;
      ac5_ac6 <= '0;
      b1_b2   <= '0;
      mc_md   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        brc_pkg::RegAc1Ac2: ac1_ac2 <= cfg_data;
        brc_pkg::RegAc3Ac4: ac3_ac4 <= cfg_data;
        brc_pkg::RegAc5Ac6: ac5_ac6 <= cfg_data;
        brc_pkg::RegB1B2:   b1_b2   <= cfg_data;
        brc_pkg::RegMcMd:   mc_md   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.ac1 = {{16{ac1_ac2[31]}}, ac1_ac2[31:16]};
    coef.ac2 = {{16{ac1_ac2[15]}}, ac1_ac2[15:0]};
    coef.ac3 = {{16{ac3_ac4[31]}}, ac3_ac4[31:16]};
    coef.ac4 = {16'd0, ac3_ac4[15:0]};
    coef.ac5 = {16'd0, ac5_ac6[31:16]};
    coef.ac6 = {16'd0, ac5_ac6[15:0]};
    coef.b1  = {{16{b1_b2[31]}}, b1_b2[31:16]};
    coef.b2  = {{16{b1_b2[15]}}, b1_b2[15:0]};
    coef.mc  = {{16{mc_md[31]}}, mc_md[31:16]};
    coef.md  = {{16{mc_md[15]}}, mc_md[15:0]};
  end
endmodule

@@ sv/brc_core.sv @@
// Compensation datapath. Everything advances on en; two dividers inline.
module brc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  brc_pkg::coef_t      coef,
  input  logic                in_valid,
  input  brc_pkg::in_item_t   in_item,
  output logic                out_valid,
  output brc_pkg::out_item_t  out_item
);
  // ---- stage A: x1 temperature product
  logic        a_v;
  logic [31:0] a_x1m;
  logic [15:0] a_up;
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_x1m <= ({16'd0, in_item.raw_temp} - coef.ac6) * coef.ac5;
      a_up  <= in_item.raw_press[23:8];
    end
  end

  // ---- stage B: den and magnitudes
  logic        b_v;
  logic [31:0] b_x1, b_na, b_nd;
  logic        b_neg, b_zero;
  logic [15:0] b_up;
  logic [31:0] x1_c, den_c, mc_sh;
  always_comb begin
    x1_c  = 32'($signed(a_x1m) >>> 15);
    den_c = x1_c + coef.md;
    mc_sh = coef.mc << 11;
  end
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= a_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_x1   <= x1_c;
      b_na   <= mc_sh[31] ? -mc_sh : mc_sh;
      b_nd   <= den_c[31] ? -den_c : den_c;
      b_neg  <= mc_sh[31] ^ den_c[31];
      b_zero <= den_c == 32'd0;
      b_up   <= a_up;
    end
  end

  localparam int unsigned S1W = 32 + 1 + 1 + 16;
  logic           d1_v;
  logic [31:0]    d1_q;
  logic [S1W-1:0] d1_s;
  brc_div #(.SideW(S1W)) u_div_t (
    .clk, .rst, .en,
    .in_valid (b_v),
    .num      (b_na),
    .den      (b_zero ? 32'd1 : b_nd),
    .side_in  ({b_x1, b_neg, b_zero, b_up}),
    .out_valid(d1_v),
    .quot     (d1_q),
    .side_out (d1_s)
  );

  // ---- stage C: b5, b6, t
  logic        c_v, c_err;
  logic [31:0] c_b6, c_t;
  logic [15:0] c_up;
  logic [31:0] x2_c, b5_c, b5r;
  always_comb begin
    x2_c = d1_s[17] ? -d1_q : d1_q;
    b5_c = d1_s[49:18] + x2_c;
    b5r  = b5_c + 32'd8;
  end
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= d1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_b6  <= b5_c - brc_pkg::TempOffset;
      c_t   <= 32'($signed(b5r) >>> 4);
      c_err <= d1_s[16];
      c_up  <= d1_s[15:0];
    end
  end

  // ---- stage D: square, linear products
  logic        d_v, d_err;
  logic [31:0] d_sqm, d_ac2b6, d_ac3b6, d_t;
  logic [15:0] d_up;
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (en) d_v <= c_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_sqm   <= c_b6 * c_b6;
      d_ac2b6 <= coef.ac2 * c_b6;
      d_ac3b6 <= coef.ac3 * c_b6;
      d_t     <= c_t;
      d_err   <= c_err;
      d_up    <= c_up;
    end
  end

  // ---- stage E: sq products
  logic        e_v, e_err;
  logic [31:0] e_b2sq, e_b1sq, e_ac2b6, e_ac3b6, e_t;
  logic [15:0] e_up;
  logic [31:0] sq_c;
  assign sq_c = 32'($signed(d_sqm) >>> 12);
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (en) e_v <= d_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_b2sq  <= coef.b2 * sq_c;
      e_b1sq  <= coef.b1 * sq_c;
      e_ac2b6 <= d_ac2b6;
      e_ac3b6 <= d_ac3b6;
      e_t     <= d_t;
      e_err   <= d_err;
      e_up    <= d_up;
    end
  end

  // ---- stage F: b3, x3
  logic        f_v, f_err;
  logic [31:0] f_b3, f_x3p, f_t;
  logic [15:0] f_up;
  logic [31:0] x3a, b3s, x3b;
  always_comb begin
    x3a = 32'($signed(e_b2sq) >>> 11) + 32'($signed(e_ac2b6) >>> 11);
    b3s = (coef.ac1 << 2) + x3a + 32'd2;
    x3b = 32'($signed(e_ac3b6) >>> 13) + 32'($signed(e_b1sq) >>> 16) + 32'd2;
  end
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (en) f_v <= e_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_b3  <= 32'($signed(b3s) >>> 2);
      f_x3p <= 32'($signed(x3b) >>> 2) + brc_pkg::HalfScale;
      f_t   <= e_t;
      f_err <= e_err;
      f_up  <= e_up;
    end
  end

  // ---- stage G: b4 product, b7 product
  logic        g_v, g_err;
  logic [31:0] g_b4m, g_b7, g_t;
  always_ff @(posedge clk) begin
    if (rst) g_v <= 1'b0;
    else if (en) g_v <= f_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g_b4m <= coef.ac4 * f_x3p;
      g_b7  <= ({16'd0, f_up} - f_b3) * brc_pkg::PressScale;
      g_t   <= f_t;
      g_err <= f_err;
    end
  end

  // ---- stage H: divider 2 setup
  logic [31:0] b4_c;
  logic        b4z, big;
  always_comb begin
    b4_c = g_b4m >> 15;
    b4z  = b4_c == 32'd0;
    big  = g_b7[31];
  end
  localparam int unsigned S2W = 32 + 1 + 1;
  logic           d2_v;
  logic [31:0]    d2_q;
  logic [S2W-1:0] d2_s;
  brc_div #(.SideW(S2W)) u_div_p (
    .clk, .rst, .en,
    .in_valid (g_v),
    .num      (big ? g_b7 : (g_b7 << 1)),
    .den      (b4z ? 32'd1 : b4_c),
    .side_in  ({g_t, big, g_err | b4z}),
    .out_valid(d2_v),
    .quot     (d2_q),
    .side_out (d2_s)
  );

  // ---- stage I: p and p>>8 square
  logic        i_v, i_err;
  logic [31:0] i_p, i_sq8, i_lin, i_t;
  logic [31:0] p_c, p8;
  always_comb begin
    p_c = d2_s[1] ? (d2_q << 1) : d2_q;
    p8  = 32'($signed(p_c) >>> 8);
  end
  always_ff @(posedge clk) begin
    if (rst) i_v <= 1'b0;
    else if (en) i_v <= d2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      i_p   <= p_c;
      i_sq8 <= p8 * p8;
      i_lin <= brc_pkg::LinCoef * p_c;
      i_t   <= d2_s[33:2];
      i_err <= d2_s[0];
    end
  end

  // ---- stage J: x1 * 3038
  logic        j_v, j_err;
  logic [31:0] j_p, j_x1m, j_lin, j_t;
  always_ff @(posedge clk) begin
    if (rst) j_v <= 1'b0;
    else if (en) j_v <= i_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      j_x1m <= i_sq8 * brc_pkg::SqCoef;
      j_p   <= i_p;
      j_lin <= i_lin;
      j_t   <= i_t;
      j_err <= i_err;
    end
  end

  // ---- final sum (registered by caller's skid)
  logic [31:0] sum_c, p_fin;
  always_comb begin
    sum_c = 32'($signed(j_x1m) >>> 16) + 32'($signed(j_lin) >>> 16)
          + brc_pkg::PressBias;
    p_fin = j_p + 32'($signed(sum_c) >>> 4);
  end

  assign out_valid            = j_v;
  assign out_item.temp_tenths = j_err ? 32'sd0 : $signed(j_t);
  assign out_item.pressure_pa = j_err ? 32'sd0 : $signed(p_fin);
  assign out_item.div_error   = j_err;
endmodule
